// File: design/fcw_pkg.sv
// Package for the FAT12 cluster chain walker: constants, item types, sequencer states.
package fcw_pkg;

  localparam int TABLE_BYTES = 8192;
  localparam int MAX_CHAIN   = 64;

  localparam int RAM_AW     = $clog2(TABLE_BYTES);
  localparam int TBL_ADDR_W = 14;
  localparam int CLUSTER_W  = 12;
  localparam int SECTOR_W   = 16;
  localparam int STEP_W     = $clog2(MAX_CHAIN + 1);
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;

  localparam logic [TBL_ADDR_W-1:0] TABLE_END  = TBL_ADDR_W'(TABLE_BYTES);
  localparam logic [STEP_W-1:0]     LAST_STEP  = STEP_W'(MAX_CHAIN - 1);
  localparam logic [CLUSTER_W-1:0]  ENTRY_MASK = 12'hFFF;
  localparam logic [CLUSTER_W-1:0]  END_MARK   = 12'hFF8;
  localparam logic [SECTOR_W-1:0]   SECTOR_BIAS      = 16'hFFFE;
  localparam logic [SECTOR_W-1:0]   DATA_START_RESET = 16'd33;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_WALK = 1'b1;

  localparam logic CFG_REG_DATA_START = 1'b0;

  typedef struct packed {
    logic        opcode;
    logic [12:0] byte_index;
    logic [7:0]  byte_value;
    logic [11:0] first_cluster;
  } in_item_t;

  typedef struct packed {
    logic [15:0] sector_index;
    logic [11:0] cluster_number;
    logic        last;
    logic        truncated;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LO   = 4'b0010,
    S_HI   = 4'b0100,
    S_CALC = 4'b1000
  } state_t;

endpackage

// File: design/fcw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module fcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/fat12_cluster_chain_walker_top.sv
// Top level of the FAT12 cluster chain walker: table RAM, step sequencer, config register.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   in_item  (fcw_pkg::in_item_t)
//   out      output     out_valid / out_stall out_item (fcw_pkg::out_item_t)
//   cfg      input      psel/penable/pwrite   paddr, pwdata, prdata, pready
//
// A load item is written to the table RAM when accepted. A walk of k clusters holds
// in_stall high while the sequencer steps through the chain; each step issues two
// byte reads on the single RAM read port and then combines them. A full output
// register that is stalled holds the sequencer in its combine step.
// Reset is synchronous; there is no clearing pass, the table is undefined until loaded.
module fat12_cluster_chain_walker_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  fcw_pkg::in_item_t           in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output fcw_pkg::out_item_t          out_item,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fcw_pkg::CFG_AW-1:0]  paddr,
  input  logic [fcw_pkg::CFG_DW-1:0]  pwdata,
  output logic [fcw_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);

  fcw_pkg::state_t                      state_r, state_nxt;
  logic [fcw_pkg::CLUSTER_W-1:0]        cur_r, cur_nxt;
  logic [fcw_pkg::STEP_W-1:0]           steps_r, steps_nxt;
  logic [fcw_pkg::TBL_ADDR_W-1:0]       base_r, base_nxt;
  logic [7:0]                           lo_r, lo_nxt;
  logic                                 lo_oob_r, lo_oob_nxt;
  logic                                 hi_oob_r, hi_oob_nxt;
  logic [fcw_pkg::SECTOR_W-1:0]         data_start_r;
  fcw_pkg::out_item_t                   out_r, out_nxt;
  logic                                 out_valid_r, out_valid_nxt;

  logic [fcw_pkg::TBL_ADDR_W-1:0]       add_a, add_b, add_sum;
  logic                                 in_accept, out_free;
  logic                                 ram_we, ram_re;
  logic [fcw_pkg::RAM_AW-1:0]           ram_raddr;
  logic [7:0]                           ram_rdata, hi_byte;
  logic [fcw_pkg::CLUSTER_W-1:0]        next_cl;
  logic                                 at_end, at_limit;

  assign in_stall  = (state_r != fcw_pkg::S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == fcw_pkg::CFG_REG_DATA_START) ?
                  {{(fcw_pkg::CFG_DW-fcw_pkg::SECTOR_W){1'b0}}, data_start_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_start_r <= fcw_pkg::DATA_START_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == fcw_pkg::CFG_REG_DATA_START) begin
      data_start_r <= pwdata[fcw_pkg::SECTOR_W-1:0];
    end
  end

  assign ram_we = in_accept && in_item.opcode == fcw_pkg::OP_LOAD &&
                  ({1'b0, in_item.byte_index} < fcw_pkg::TABLE_END);

  fcw_ram #(
    .WIDTH(8),
    .DEPTH(fcw_pkg::TABLE_BYTES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(in_item.byte_index[fcw_pkg::RAM_AW-1:0]),
    .wdata(in_item.byte_value),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // shared address adder: 3n/2 = n + n/2, then base + 1
  always_comb begin
    add_a = '0;
    add_b = '0;
    case (state_r)
      fcw_pkg::S_LO: begin
        add_a = {2'b00, cur_r};
        add_b = {3'b000, cur_r[fcw_pkg::CLUSTER_W-1:1]};
      end
      fcw_pkg::S_HI: begin
        add_a = base_r;
        add_b = {{(fcw_pkg::TBL_ADDR_W-1){1'b0}}, 1'b1};
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end
  assign add_sum   = add_a + add_b;
  assign ram_raddr = add_sum[fcw_pkg::RAM_AW-1:0];

  assign hi_byte  = hi_oob_r ? 8'h00 : ram_rdata;
  assign next_cl  = cur_r[0] ? ({hi_byte, lo_r[7:4]} & fcw_pkg::ENTRY_MASK)
                             : ({hi_byte[3:0], lo_r} & fcw_pkg::ENTRY_MASK);
  assign at_end   = (next_cl >= fcw_pkg::END_MARK);
  assign at_limit = (steps_r >= fcw_pkg::LAST_STEP);

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    steps_nxt     = steps_r;
    base_nxt      = base_r;
    lo_nxt        = lo_r;
    lo_oob_nxt    = lo_oob_r;
    hi_oob_nxt    = hi_oob_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_re        = 1'b0;
    case (state_r)
      fcw_pkg::S_IDLE: begin
        if (in_accept && in_item.opcode == fcw_pkg::OP_WALK) begin
          cur_nxt   = in_item.first_cluster;
          steps_nxt = '0;
          state_nxt = fcw_pkg::S_LO;
        end
      end
      fcw_pkg::S_LO: begin
        ram_re     = 1'b1;
        base_nxt   = add_sum;
        lo_oob_nxt = (add_sum >= fcw_pkg::TABLE_END);
        state_nxt  = fcw_pkg::S_HI;
      end
      fcw_pkg::S_HI: begin
        ram_re     = 1'b1;
        hi_oob_nxt = (add_sum >= fcw_pkg::TABLE_END);
        lo_nxt     = lo_oob_r ? 8'h00 : ram_rdata;
        state_nxt  = fcw_pkg::S_CALC;
      end
      fcw_pkg::S_CALC: begin
        if (out_free) begin
          out_nxt.sector_index   = data_start_r + {4'h0, cur_r} + fcw_pkg::SECTOR_BIAS;
          out_nxt.cluster_number = cur_r;
          out_nxt.last           = at_end || at_limit;
          out_nxt.truncated      = !at_end && at_limit;
          out_valid_nxt          = 1'b1;
          steps_nxt              = steps_r + 1'b1;
          if (at_end || at_limit) begin
            state_nxt = fcw_pkg::S_IDLE;
          end else begin
            cur_nxt   = next_cl;
            state_nxt = fcw_pkg::S_LO;
          end
        end
      end
      default: begin
        state_nxt = fcw_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fcw_pkg::S_IDLE;
      cur_r       <= '0;
      steps_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      steps_r     <= steps_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r   <= base_nxt;
    lo_r     <= lo_nxt;
    lo_oob_r <= lo_oob_nxt;
    hi_oob_r <= hi_oob_nxt;
    out_r    <= out_nxt;
  end

endmodule

// File: design/fcw_checker.sv
// Port-level checker for the FAT12 cluster chain walker, bound to the top level.
module fcw_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input fcw_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_stall,
  input fcw_pkg::out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result item changed or dropped");

  a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.truncated |-> out_item.last)
    else $error("truncated result item not marked last");

  a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_item.opcode == fcw_pkg::OP_WALK |=> in_stall)
    else $error("walk item accepted but input not stalled");

  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_item.opcode == fcw_pkg::OP_LOAD |=> !in_stall)
    else $error("load item did not complete in one cycle");

endmodule

bind fat12_cluster_chain_walker_top fcw_checker u_fcw_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_item  (in_item),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_item (out_item)
);
